// ----- rtl/macd_pkg.sv -----
// ============================================================================
// macd_pkg: shared definitions for the streaming MACD core
// Widths, request and register codes, control words and the microcode table
// that sequences the shared EMA multiplier.
// ============================================================================
package macd_pkg;

    // Default parameter values.
    localparam int PRICE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Fixed field widths.
    localparam int REQ_W   = 2;
    localparam int TIME_W  = 64;
    localparam int OUT_W   = 48;
    localparam int COUNT_W = 2;

    // Smoothing factors are Q1.16 held in 17 bits.
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST   = ALPHA_W'(10082);
    localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RST   = ALPHA_W'(4855);
    localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RST = ALPHA_W'(13107);

    // Configuration port.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // Request codes carried in each input word.
    typedef enum logic [REQ_W-1:0] {
        REQ_CLOSED = 2'd0,
        REQ_BUILD  = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_e;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_FAST_ALPHA   = 2'd0,
        REG_SLOW_ALPHA   = 2'd1,
        REG_SIGNAL_ALPHA = 2'd2
    } reg_idx_e;

    // Candle count codes; the count saturates at two.
    localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
    localparam logic [COUNT_W-1:0] COUNT_MANY = 2'd2;

    // Which EMA the shared multiplier or adder works on.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_FAST = 2'd1,
        OP_SLOW = 2'd2,
        OP_SIG  = 2'd3
    } op_e;

    // Datapath control for one step.
    typedef struct packed {
        logic start;   // load working registers for the item
        op_e  mul;     // multiply (x - ema) by alpha
        op_e  add;     // add the scaled product back into the ema
        logic ld_m;    // latch the saturated MACD line
        logic emit;    // write the result word and commit state
    } ctrl_t;

    localparam int STEP_W      = 3;
    localparam int UCODE_DEPTH = 8;
    localparam logic [STEP_W-1:0] STEP_EMIT = STEP_W'(UCODE_DEPTH - 1);

    // One microcode word: datapath control plus sequencing.
    typedef struct packed {
        ctrl_t              ctrl;
        logic               jmp;     // jump to target on the short path
        logic [STEP_W-1:0]  target;
        logic               last;    // final step of the program
    } ucode_t;

    localparam ctrl_t CTRL_NOP = '{1'b0, OP_NONE, OP_NONE, 1'b0, 1'b0};

    // Program: start, fast EMA, slow EMA, MACD, signal EMA, emit.
    // Seeding and the empty-stream preview jump straight to the emit step.
    localparam ucode_t UCODE [UCODE_DEPTH] = '{
        '{'{1'b1, OP_NONE, OP_NONE, 1'b0, 1'b0}, 1'b1, STEP_EMIT, 1'b0},
        '{'{1'b0, OP_FAST, OP_NONE, 1'b0, 1'b0}, 1'b0, '0,        1'b0},
        '{'{1'b0, OP_SLOW, OP_FAST, 1'b0, 1'b0}, 1'b0, '0,        1'b0},
        '{'{1'b0, OP_NONE, OP_SLOW, 1'b0, 1'b0}, 1'b0, '0,        1'b0},
        '{'{1'b0, OP_NONE, OP_NONE, 1'b1, 1'b0}, 1'b0, '0,        1'b0},
        '{'{1'b0, OP_SIG,  OP_NONE, 1'b0, 1'b0}, 1'b0, '0,        1'b0},
        '{'{1'b0, OP_NONE, OP_SIG,  1'b0, 1'b0}, 1'b0, '0,        1'b0},
        '{'{1'b0, OP_NONE, OP_NONE, 1'b0, 1'b1}, 1'b0, '0,        1'b1}
    };

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic short_path;  // item needs no EMA update
        logic out_free;    // result register can take a word
    } status_t;

    // Effective smoothing factors.
    typedef struct packed {
        logic [ALPHA_W-1:0] fast;
        logic [ALPHA_W-1:0] slow;
        logic [ALPHA_W-1:0] sig;
    } alpha_t;

    // A factor above one acts as one.
    function automatic logic [ALPHA_W-1:0] alpha_eff(input logic [ALPHA_W-1:0] a);
        return (a > ALPHA_ONE) ? ALPHA_ONE : a;
    endfunction

endpackage

// ----- rtl/macd_if.sv -----
// ============================================================================
// macd_if: valid/ready channels of the MACD core
// Request channel carries candles; response channel carries MACD results.
// ============================================================================
interface macd_req_if import macd_pkg::*; #(
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF
) ();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [TIME_W-1:0] candle_time;
    logic [PRICE_WIDTH-1:0]   close_price;

    modport source (output valid, req_type, candle_time, close_price, input ready);
    modport sink   (input valid, req_type, candle_time, close_price, output ready);
endinterface

interface macd_rsp_if import macd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] macd_value;
    logic signed [OUT_W-1:0] signal_value;
    logic signed [OUT_W-1:0] histogram_value;

    modport source (output valid, macd_value, signal_value, histogram_value, input ready);
    modport sink   (input valid, macd_value, signal_value, histogram_value, output ready);
endinterface

// ----- rtl/macd_cfg.sv -----
// ============================================================================
// macd_cfg: configuration registers
// Holds the three smoothing factors behind an APB-style port and presents
// their clamped values to the datapath.
// ============================================================================
module macd_cfg import macd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output alpha_t                alpha
);

    logic [ALPHA_W-1:0] fast_alpha_reg, fast_alpha_next;
    logic [ALPHA_W-1:0] slow_alpha_reg, slow_alpha_next;
    logic [ALPHA_W-1:0] signal_alpha_reg, signal_alpha_next;
    logic               wr_en;
    reg_idx_e           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_e'(paddr[3:2]);

    // Register write decode.
    always_comb
    begin
        fast_alpha_next   = fast_alpha_reg;
        slow_alpha_next   = slow_alpha_reg;
        signal_alpha_next = signal_alpha_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_FAST_ALPHA:   fast_alpha_next   = pwdata[ALPHA_W-1:0];
                REG_SLOW_ALPHA:   slow_alpha_next   = pwdata[ALPHA_W-1:0];
                REG_SIGNAL_ALPHA: signal_alpha_next = pwdata[ALPHA_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_alpha_reg   <= FAST_ALPHA_RST;
            slow_alpha_reg   <= SLOW_ALPHA_RST;
            signal_alpha_reg <= SIGNAL_ALPHA_RST;
        end
        else
        begin
            fast_alpha_reg   <= fast_alpha_next;
            slow_alpha_reg   <= slow_alpha_next;
            signal_alpha_reg <= signal_alpha_next;
        end
    end

    // Read back returns the stored value.
    always_comb
    begin
        unique case (idx)
            REG_FAST_ALPHA:   prdata = CFG_DATA_W'(fast_alpha_reg);
            REG_SLOW_ALPHA:   prdata = CFG_DATA_W'(slow_alpha_reg);
            REG_SIGNAL_ALPHA: prdata = CFG_DATA_W'(signal_alpha_reg);
            default:          prdata = '0;
        endcase
    end

    // Factors above one are clamped for use.
    assign alpha.fast = alpha_eff(fast_alpha_reg);
    assign alpha.slow = alpha_eff(slow_alpha_reg);
    assign alpha.sig  = alpha_eff(signal_alpha_reg);

endmodule

// ----- rtl/macd_seq.sv -----
// ============================================================================
// macd_seq: microcode sequencer
// Steps through the control table for each candle, taking the short path
// for seeding and empty previews and holding the emit step while the
// result register is full.
// ============================================================================
module macd_seq import macd_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [REQ_W-1:0] in_req_type,
    input  status_t          status,
    output logic             in_ready,
    output ctrl_t            ctrl
);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            word;
    logic              stall;

    assign word     = UCODE[step_reg];
    assign stall    = word.ctrl.emit && !status.out_free;
    assign in_ready = !busy_reg;

    // Step counter with conditional jump.
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        ctrl      = CTRL_NOP;
        if (!busy_reg)
        begin
            if (in_fire)
            begin
                unique case (req_e'(in_req_type))
                    REQ_CLOSED, REQ_BUILD:
                    begin
                        busy_next = 1'b1;
                        step_next = '0;
                    end
                    default: ;
                endcase
            end
        end
        else if (!stall)
        begin
            ctrl = word.ctrl;
            priority if (word.last)
                busy_next = 1'b0;
            else if (word.jmp && status.short_path)
                step_next = word.target;
            else
                step_next = step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

// ----- rtl/macd_dp.sv -----
// ============================================================================
// macd_dp: MACD datapath
// Indicator state, working registers, one shared EMA multiplier and the
// result register, all driven by the microcode control word.
// ============================================================================
module macd_dp import macd_pkg::*; #(
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_fire,
    input  logic [REQ_W-1:0]         in_req_type,
    input  logic signed [TIME_W-1:0] in_candle_time,
    input  logic [PRICE_WIDTH-1:0]   in_close_price,
    input  alpha_t                   alpha,
    input  ctrl_t                    ctrl,
    output status_t                  status,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  macd_value,
    output logic signed [OUT_W-1:0]  signal_value,
    output logic signed [OUT_W-1:0]  histogram_value
);

    localparam int SCALED_W = PRICE_WIDTH + FRAC_BITS;
    localparam int EMA_W    = (SCALED_W > 63) ? 63 : SCALED_W;
    localparam int DIFF_W   = ((EMA_W > OUT_W) ? EMA_W : OUT_W) + 1;
    localparam int PROD_W   = DIFF_W + ALPHA_W + 1;
    localparam int Q_W      = PROD_W - ALPHA_FRAC;

    localparam logic signed [DIFF_W-1:0] SAT_HI =
        {{(DIFF_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [DIFF_W-1:0] SAT_LO =
        {{(DIFF_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic closed;
        logic seed;
        logic zero;
        logic replace;
        logic new_adv;
    } mode_t;

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [DIFF_W-1:0] v);
        if (v > SAT_HI)
            return SAT_HI[OUT_W-1:0];
        else if (v < SAT_LO)
            return SAT_LO[OUT_W-1:0];
        else
            return v[OUT_W-1:0];
    endfunction

    // Indicator state.
    logic [EMA_W-1:0]   fast_reg, fast_next, slow_reg, slow_next;
    logic [OUT_W-1:0]   sig_reg, sig_next;
    logic [EMA_W-1:0]   pfast_reg, pfast_next, pslow_reg, pslow_next;
    logic [OUT_W-1:0]   psig_reg, psig_next;
    logic [TIME_W-1:0]  last_time_reg, last_time_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    mode_t              mode_reg, mode_next;
    logic               out_valid_reg, out_valid_next;

    // Working registers and the item being processed.
    logic [EMA_W-1:0]   wf_reg, wf_next, ws_reg, ws_next;
    logic [OUT_W-1:0]   wg_reg, wg_next, m_reg, m_next;
    logic [Q_W-1:0]     prod_reg, prod_next;
    logic [EMA_W-1:0]   x_reg, x_next;
    logic [TIME_W-1:0]  t_reg, t_next;
    logic [OUT_W-1:0]   macd_reg, macd_next, sigout_reg, sigout_next;
    logic [OUT_W-1:0]   hist_reg, hist_next;

    logic [SCALED_W-1:0]      scaled;
    logic                     is_closed, is_build, is_clear, time_match;
    logic signed [DIFF_W-1:0] mul_a;
    logic [ALPHA_W-1:0]       mul_alpha;
    logic signed [PROD_W-1:0] prod_full;
    logic signed [Q_W-1:0]    sum_fast, sum_slow, sum_sig;
    logic signed [DIFF_W-1:0] diff_fs, diff_mg;

    // Request decode against the current stream state.
    assign scaled     = {in_close_price, {FRAC_BITS{1'b0}}};
    assign is_closed  = in_fire && (req_e'(in_req_type) == REQ_CLOSED);
    assign is_build   = in_fire && (req_e'(in_req_type) == REQ_BUILD);
    assign is_clear   = in_fire && (req_e'(in_req_type) == REQ_CLEAR);
    assign time_match = (count_reg != COUNT_NONE) && (in_candle_time == last_time_reg);

    assign status.short_path = mode_reg.seed || mode_reg.zero;
    assign status.out_free   = !out_valid_reg || out_ready;

    // Shared multiplier: difference toward the target, times alpha.
    always_comb
    begin
        unique case (ctrl.mul)
            OP_FAST:
            begin
                mul_a     = $signed({{(DIFF_W-EMA_W){1'b0}}, x_reg})
                          - $signed({{(DIFF_W-EMA_W){1'b0}}, wf_reg});
                mul_alpha = alpha.fast;
            end
            OP_SLOW:
            begin
                mul_a     = $signed({{(DIFF_W-EMA_W){1'b0}}, x_reg})
                          - $signed({{(DIFF_W-EMA_W){1'b0}}, ws_reg});
                mul_alpha = alpha.slow;
            end
            OP_SIG:
            begin
                mul_a     = $signed({{(DIFF_W-OUT_W){m_reg[OUT_W-1]}}, m_reg})
                          - $signed({{(DIFF_W-OUT_W){wg_reg[OUT_W-1]}}, wg_reg});
                mul_alpha = alpha.sig;
            end
            default:
            begin
                mul_a     = '0;
                mul_alpha = '0;
            end
        endcase
    end

    assign prod_full = mul_a * $signed({1'b0, mul_alpha});

    // Sums of the EMA updates; dropping low product bits floors the quotient.
    assign sum_fast = $signed({{(Q_W-EMA_W){1'b0}}, wf_reg}) + $signed(prod_reg);
    assign sum_slow = $signed({{(Q_W-EMA_W){1'b0}}, ws_reg}) + $signed(prod_reg);
    assign sum_sig  = $signed({{(Q_W-OUT_W){wg_reg[OUT_W-1]}}, wg_reg}) + $signed(prod_reg);

    assign diff_fs = $signed({{(DIFF_W-EMA_W){1'b0}}, wf_reg})
                   - $signed({{(DIFF_W-EMA_W){1'b0}}, ws_reg});
    assign diff_mg = $signed({{(DIFF_W-OUT_W){m_reg[OUT_W-1]}}, m_reg})
                   - $signed({{(DIFF_W-OUT_W){wg_reg[OUT_W-1]}}, wg_reg});

    // Working registers and item capture.
    always_comb
    begin
        x_next      = x_reg;
        t_next      = t_reg;
        wf_next     = wf_reg;
        ws_next     = ws_reg;
        wg_next     = wg_reg;
        m_next      = m_reg;
        prod_next   = prod_reg;
        macd_next   = macd_reg;
        sigout_next = sigout_reg;
        hist_next   = hist_reg;

        if (in_fire)
        begin
            x_next = scaled[EMA_W-1:0];
            t_next = in_candle_time;
        end

        // Starting values: seed, empty preview, saved prior states or current.
        if (ctrl.start)
        begin
            m_next = '0;
            priority if (mode_reg.seed)
            begin
                wf_next = x_reg;
                ws_next = x_reg;
                wg_next = '0;
            end
            else if (mode_reg.zero)
            begin
                wf_next = '0;
                ws_next = '0;
                wg_next = '0;
            end
            else if (mode_reg.replace)
            begin
                wf_next = pfast_reg;
                ws_next = pslow_reg;
                wg_next = psig_reg;
            end
            else
            begin
                wf_next = fast_reg;
                ws_next = slow_reg;
                wg_next = sig_reg;
            end
        end

        if (ctrl.mul != OP_NONE)
            prod_next = prod_full[PROD_W-1:ALPHA_FRAC];

        unique case (ctrl.add)
            OP_FAST: wf_next = sum_fast[EMA_W-1:0];
            OP_SLOW: ws_next = sum_slow[EMA_W-1:0];
            OP_SIG:  wg_next = sum_sig[OUT_W-1:0];
            default: ;
        endcase

        if (ctrl.ld_m)
            m_next = sat_out(diff_fs);

        if (ctrl.emit)
        begin
            macd_next   = m_reg;
            sigout_next = wg_reg;
            hist_next   = sat_out(diff_mg);
        end
    end

    // Stream state: decode on accept, commit on the emit of a closed candle, clear on request.
    always_comb
    begin
        fast_next      = fast_reg;
        slow_next      = slow_reg;
        sig_next       = sig_reg;
        pfast_next     = pfast_reg;
        pslow_next     = pslow_reg;
        psig_next      = psig_reg;
        last_time_next = last_time_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg;

        if (is_closed || is_build)
        begin
            mode_next.closed  = is_closed;
            mode_next.seed    = is_closed && ((count_reg == COUNT_NONE)
                                || (time_match && (count_reg == COUNT_ONE)));
            mode_next.zero    = is_build && (count_reg == COUNT_NONE);
            mode_next.replace = is_closed && time_match && (count_reg == COUNT_MANY);
            mode_next.new_adv = is_closed && !time_match && (count_reg != COUNT_NONE);
        end

        if (ctrl.emit && mode_reg.closed)
        begin
            fast_next      = wf_reg;
            slow_next      = ws_reg;
            sig_next       = wg_reg;
            last_time_next = t_reg;
            if (mode_reg.new_adv)
            begin
                pfast_next = fast_reg;
                pslow_next = slow_reg;
                psig_next  = sig_reg;
                count_next = COUNT_MANY;
            end
            else if (count_reg == COUNT_NONE)
            begin
                count_next = COUNT_ONE;
            end
        end

        if (is_clear)
        begin
            fast_next      = '0;
            slow_next      = '0;
            sig_next       = '0;
            pfast_next     = '0;
            pslow_next     = '0;
            psig_next      = '0;
            last_time_next = '0;
            count_next     = COUNT_NONE;
        end

        // Result register handshake.
        if (ctrl.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fast_reg      <= '0;
            slow_reg      <= '0;
            sig_reg       <= '0;
            pfast_reg     <= '0;
            pslow_reg     <= '0;
            psig_reg      <= '0;
            last_time_reg <= '0;
            count_reg     <= COUNT_NONE;
            mode_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fast_reg      <= fast_next;
            slow_reg      <= slow_next;
            sig_reg       <= sig_next;
            pfast_reg     <= pfast_next;
            pslow_reg     <= pslow_next;
            psig_reg      <= psig_next;
            last_time_reg <= last_time_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        t_reg      <= t_next;
        wf_reg     <= wf_next;
        ws_reg     <= ws_next;
        wg_reg     <= wg_next;
        m_reg      <= m_next;
        prod_reg   <= prod_next;
        macd_reg   <= macd_next;
        sigout_reg <= sigout_next;
        hist_reg   <= hist_next;
    end

    assign out_valid       = out_valid_reg;
    assign macd_value      = $signed(macd_reg);
    assign signal_value    = $signed(sigout_reg);
    assign histogram_value = $signed(hist_reg);

endmodule

// ----- rtl/macd_stream_indicator_core.sv -----
// A closed or building candle that updates the EMAs passes through the start,
// fast EMA, slow EMA, MACD, signal EMA and emit steps; seeding and an empty-stream
// preview jump from the start step straight to emit. A new candle is taken only
// once the emit step has run, and emit holds while the result register is full;
// the fast, slow and signal EMA updates share one multiplier in turn. A clear is taken while idle and gives no word.
// Reset (rst_n low, asynchronous) empties the stream and restores the factors.
// ============================================================================
// macd_stream_indicator_core: streaming MACD indicator
// Microcoded core computing MACD, signal and histogram from candle closes.
// ============================================================================
module macd_stream_indicator_core import macd_pkg::*; #(
    parameter int PRICE_WIDTH = PRICE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    macd_req_if.sink              req,
    macd_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    alpha_t  alpha;
    ctrl_t   ctrl;
    status_t status;
    logic    in_ready;
    logic    in_fire;

    // Accept an input word when the sequencer is idle.
    assign req.ready = in_ready;
    assign in_fire   = req.valid && in_ready;

    macd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .alpha   (alpha)
    );

    macd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .in_req_type (req.req_type),
        .status      (status),
        .in_ready    (in_ready),
        .ctrl        (ctrl)
    );

    macd_dp #(
        .PRICE_WIDTH (PRICE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_fire         (in_fire),
        .in_req_type     (req.req_type),
        .in_candle_time  (req.candle_time),
        .in_close_price  (req.close_price),
        .alpha           (alpha),
        .ctrl            (ctrl),
        .status          (status),
        .out_valid       (rsp.valid),
        .out_ready       (rsp.ready),
        .macd_value      (rsp.macd_value),
        .signal_value    (rsp.signal_value),
        .histogram_value (rsp.histogram_value)
    );

endmodule
